### src/tilemap_quad_vertex_generator_macros.svh
// assertion macros shared by the tile map vertex generator rtl
`ifndef TILEMAP_QUAD_VERTEX_GENERATOR_MACROS_SVH
`define TILEMAP_QUAD_VERTEX_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication under reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: label");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

### src/tqv_pkg.sv
// package with widths, codes and corner tables of the tile map vertex generator
`timescale 1ns / 1ps

package tqv_pkg;

    // field and register widths
    localparam int TILE_INDEX_W  = 16;
    localparam int POS_W         = 21;
    localparam int TEX_W         = 25;
    localparam int MAP_REG_W     = 13;
    localparam int TILE_DIM_W    = 9;
    localparam int TEXW_REG_W    = 15;
    localparam int PER_ROW_W     = 15;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 15;
    localparam int OUT_FIELDS_W  = 2 * POS_W + 2 * TEX_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // limits and reset values
    localparam int MAP_DIM_MAX_DEF   = 4096;
    localparam int TILE_DIM_MAX      = 256;
    localparam int MAP_WIDTH_RST     = 1;
    localparam int MAP_HEIGHT_RST    = 1;
    localparam int TILE_WIDTH_RST    = 16;
    localparam int TILE_HEIGHT_RST   = 16;
    localparam int TEXTURE_WIDTH_RST = 256;
    localparam int PER_ROW_RST       = TEXTURE_WIDTH_RST / TILE_WIDTH_RST;

    // vertices per tile
    localparam int VERTS_PER_TILE = 6;
    localparam int VERT_IDX_W     = $clog2(VERTS_PER_TILE);

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_WIDTH     = 3'd0,
        REG_MAP_HEIGHT    = 3'd1,
        REG_TILE_WIDTH    = 3'd2,
        REG_TILE_HEIGHT   = 3'd3,
        REG_TEXTURE_WIDTH = 3'd4
    } tqv_reg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } tqv_state_t;

    // corner offsets of the two triangles
    localparam logic [VERTS_PER_TILE-1:0] CORNER_DX = 6'b110010;
    localparam logic [VERTS_PER_TILE-1:0] CORNER_DY = 6'b101100;

    function automatic logic corner_dx(input logic [VERT_IDX_W-1:0] k);
        return CORNER_DX[k];
    endfunction

    function automatic logic corner_dy(input logic [VERT_IDX_W-1:0] k);
        return CORNER_DY[k];
    endfunction

endpackage

### src/tilemap_quad_vertex_generator.sv
// top level of the tile map quad vertex generator
// Takes one tileset index per map cell in raster order and emits six vertices (two
// triangles) per tile with screen position and texture coordinate in pixels. An
// accepted index passes through the bit-serial divider that splits the index by
// tiles-per-row, a handoff into the bit-serial multipliers that scale by the tile
// size, and a handoff into the emit phase, which gives one vertex per cycle while the
// output is not stalled; a stalled output holds the sequencer in its emit phase. A
// write to tile_width or texture_width starts a pass through the same divider to
// recompute tiles-per-row; no tile index is taken until that pass is done. The next
// index is taken while the sixth vertex still waits in the output register.
`timescale 1ns / 1ps
`include "tilemap_quad_vertex_generator_macros.svh"

module tilemap_quad_vertex_generator
    import tqv_pkg::*;
#(
    parameter int MAP_DIM_MAX = MAP_DIM_MAX_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // tile index requests
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [TILE_INDEX_W-1:0] s_axis_tdata,   // tile_index
    // vertex output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // pos_x, pos_y, tex_x, tex_y
    output logic                    m_axis_tlast    // vertex_last
);

    localparam int CNT_W = (MAP_DIM_MAX > 1) ? $clog2(MAP_DIM_MAX) : 1;
    localparam int DIM_W = $clog2(MAP_DIM_MAX + 1);
    localparam int CMP_W = ((MAP_REG_W > DIM_W) ? MAP_REG_W : DIM_W) + 1;

    // configuration registers
    logic [MAP_REG_W-1:0]  map_width_reg, map_height_reg;
    logic [TILE_DIM_W-1:0] tile_width_reg, tile_height_reg;
    logic [TEXW_REG_W-1:0] texture_width_reg;
    logic                  rate_dirty_reg, rate_dirty_next;
    logic [PER_ROW_W-1:0]  per_row_reg, per_row_next;

    // state
    tqv_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic [VERT_IDX_W-1:0] vert_reg, vert_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      pos_x_reg, pos_y_reg;
    logic [TEX_W-1:0]      tex_x_reg, tex_y_reg;
    logic                  last_reg;
    logic                  out_load;

    // clamped settings
    logic [TILE_DIM_W-1:0] tw_c, th_c;
    logic [CMP_W-1:0]      mw_c, mh_c;
    logic [CMP_W-1:0]      col_p1, row_p1;

    // divider and multiplier hookup
    logic                    div_start, div_done;
    logic [TILE_INDEX_W-1:0] div_dividend, div_quot;
    logic [PER_ROW_W-1:0]    div_divisor, div_rem;
    logic                    mul_start;
    logic                    px_done, py_done, tx_done, ty_done;
    logic [POS_W-1:0]        px_base, py_base;
    logic [TEX_W-1:0]        tx_base, ty_base;
    logic                    s_accept;
    logic                    rate_write;

    // check helpers
    logic                    div_owner_st;
    logic                    vert_is_last;

    // clamp tile sizes to 1..256
    always_comb
    begin
        priority if (tile_width_reg == '0)
            tw_c = TILE_DIM_W'(1);
        else if (tile_width_reg > TILE_DIM_W'(TILE_DIM_MAX))
            tw_c = TILE_DIM_W'(TILE_DIM_MAX);
        else
            tw_c = tile_width_reg;

        priority if (tile_height_reg == '0)
            th_c = TILE_DIM_W'(1);
        else if (tile_height_reg > TILE_DIM_W'(TILE_DIM_MAX))
            th_c = TILE_DIM_W'(TILE_DIM_MAX);
        else
            th_c = tile_height_reg;
    end

    // clamp map size to 1..MAP_DIM_MAX
    always_comb
    begin
        priority if (map_width_reg == '0)
            mw_c = CMP_W'(1);
        else if (CMP_W'(map_width_reg) > CMP_W'(MAP_DIM_MAX))
            mw_c = CMP_W'(MAP_DIM_MAX);
        else
            mw_c = CMP_W'(map_width_reg);

        priority if (map_height_reg == '0)
            mh_c = CMP_W'(1);
        else if (CMP_W'(map_height_reg) > CMP_W'(MAP_DIM_MAX))
            mh_c = CMP_W'(MAP_DIM_MAX);
        else
            mh_c = CMP_W'(map_height_reg);
    end

    assign col_p1 = CMP_W'(col_reg) + CMP_W'(1);
    assign row_p1 = CMP_W'(row_reg) + CMP_W'(1);

    // configuration writes
    assign rate_write = cfg_we && ((cfg_index == REG_TILE_WIDTH) ||
                                   (cfg_index == REG_TEXTURE_WIDTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg     <= MAP_REG_W'(MAP_WIDTH_RST);
            map_height_reg    <= MAP_REG_W'(MAP_HEIGHT_RST);
            tile_width_reg    <= TILE_DIM_W'(TILE_WIDTH_RST);
            tile_height_reg   <= TILE_DIM_W'(TILE_HEIGHT_RST);
            texture_width_reg <= TEXW_REG_W'(TEXTURE_WIDTH_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:     map_width_reg     <= cfg_data[MAP_REG_W-1:0];
                REG_MAP_HEIGHT:    map_height_reg    <= cfg_data[MAP_REG_W-1:0];
                REG_TILE_WIDTH:    tile_width_reg    <= cfg_data[TILE_DIM_W-1:0];
                REG_TILE_HEIGHT:   tile_height_reg   <= cfg_data[TILE_DIM_W-1:0];
                REG_TEXTURE_WIDTH: texture_width_reg <= cfg_data[TEXW_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // shared divider: tiles-per-row, then index split
    tqv_divider #(
        .DVD_W (TILE_INDEX_W),
        .DVS_W (PER_ROW_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // four scalers run side by side
    tqv_serial_mult #(.A_W(CNT_W), .B_W(TILE_DIM_W), .P_W(POS_W)) u_mul_px (
        .clk (clk), .rst_n (rst_n), .start (mul_start),
        .a (col_reg), .b (tw_c), .done (px_done), .product (px_base)
    );

    tqv_serial_mult #(.A_W(CNT_W), .B_W(TILE_DIM_W), .P_W(POS_W)) u_mul_py (
        .clk (clk), .rst_n (rst_n), .start (mul_start),
        .a (row_reg), .b (th_c), .done (py_done), .product (py_base)
    );

    tqv_serial_mult #(.A_W(PER_ROW_W), .B_W(TILE_DIM_W), .P_W(TEX_W)) u_mul_tx (
        .clk (clk), .rst_n (rst_n), .start (mul_start),
        .a (div_rem), .b (tw_c), .done (tx_done), .product (tx_base)
    );

    tqv_serial_mult #(.A_W(TILE_INDEX_W), .B_W(TILE_DIM_W), .P_W(TEX_W)) u_mul_ty (
        .clk (clk), .rst_n (rst_n), .start (mul_start),
        .a (div_quot), .b (th_c), .done (ty_done), .product (ty_base)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && !rate_dirty_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        rate_dirty_next = rate_dirty_reg;
        per_row_next    = per_row_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        vert_next       = vert_reg;
        div_start       = 1'b0;
        div_dividend    = s_axis_tdata;
        div_divisor     = per_row_reg;
        mul_start       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rate_dirty_reg)
                begin
                    div_start       = 1'b1;
                    div_dividend    = TILE_INDEX_W'(texture_width_reg);
                    div_divisor     = PER_ROW_W'(tw_c);
                    rate_dirty_next = 1'b0;
                    state_next      = ST_RATE;
                end
                else if (s_accept)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_RATE:
            begin
                if (div_done)
                begin
                    per_row_next = (div_quot == '0) ? PER_ROW_W'(1)
                                                    : div_quot[PER_ROW_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (px_done && py_done && tx_done && ty_done)
                begin
                    vert_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    if (vert_reg == VERT_IDX_W'(VERTS_PER_TILE - 1))
                    begin
                        state_next = ST_IDLE;
                        // advance the map position
                        if (col_p1 >= mw_c)
                        begin
                            col_next = '0;
                            row_next = (row_p1 >= mh_c) ? '0 : row_reg + CNT_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        vert_next = vert_reg + VERT_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write of a size that feeds tiles-per-row wins over the clear
        if (rate_write)
        begin
            rate_dirty_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rate_dirty_reg <= 1'b0;
            per_row_reg    <= PER_ROW_W'(PER_ROW_RST);
            col_reg        <= '0;
            row_reg        <= '0;
            vert_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rate_dirty_reg <= rate_dirty_next;
            per_row_reg    <= per_row_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            vert_reg       <= vert_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // vertex output register: base plus one tile step on the far corners
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_x_reg <= px_base + (corner_dx(vert_reg) ? POS_W'(tw_c) : '0);
            pos_y_reg <= py_base + (corner_dy(vert_reg) ? POS_W'(th_c) : '0);
            tex_x_reg <= tx_base + (corner_dx(vert_reg) ? TEX_W'(tw_c) : '0);
            tex_y_reg <= ty_base + (corner_dy(vert_reg) ? TEX_W'(th_c) : '0);
            last_reg  <= (vert_reg == VERT_IDX_W'(VERTS_PER_TILE - 1));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                            tex_y_reg, tex_x_reg, pos_y_reg, pos_x_reg};

    // checks
    assign div_owner_st = (state_reg == ST_RATE) || (state_reg == ST_DIV);
    assign vert_is_last = (vert_reg == VERT_IDX_W'(VERTS_PER_TILE - 1));

    `ASSERT_NEXT(a_accept_starts_split, clk, rst_n, s_accept, state_reg == ST_DIV)
    `ASSERT_IMPLIES(a_div_done_owned, clk, rst_n, div_done, div_owner_st)
    `ASSERT_IMPLIES(a_per_row_nonzero, clk, rst_n, 1'b1, per_row_reg != '0)
    `ASSERT_IMPLIES(a_last_only_sixth, clk, rst_n, out_load && !vert_is_last, state_next == ST_EMIT)

endmodule

### src/tqv_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tqv_divider
    import tqv_pkg::*;
#(
    parameter int DVD_W = TILE_INDEX_W,
    parameter int DVS_W = PER_ROW_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one trial subtraction per cycle
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where dividend bits leave
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### src/tqv_serial_mult.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module tqv_serial_mult
    import tqv_pkg::*;
#(
    parameter int A_W = TILE_INDEX_W,
    parameter int B_W = TILE_DIM_W,
    parameter int P_W = TEX_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [P_W-1:0]   mcd_reg, mcd_next;
    logic [B_W-1:0]   mpr_reg, mpr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpr_next  = mpr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mcd_next  = P_W'(a);
            mpr_next  = b;
            cnt_next  = CNT_W'(B_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand where the multiplier bit is set
            if (mpr_reg[0])
            begin
                acc_next = acc_reg + mcd_reg;
            end
            mcd_next = {mcd_reg[P_W-2:0], 1'b0};
            mpr_next = mpr_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpr_reg <= mpr_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
